@@ hw/rtl/two_level_dirty_hint_bitmap_top_macros.svh @@
// Assertion macros for the two-level hint bitmap checker.
// Included by the checker file only; depends on nothing else.
`ifndef TWO_LEVEL_DIRTY_HINT_BITMAP_TOP_MACROS_SVH
`define TWO_LEVEL_DIRTY_HINT_BITMAP_TOP_MACROS_SVH

// Check a property on the rising clock edge, skipped while reset is held.
`define TLDHB_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("hint bitmap check failed");

// Check a property on the rising clock edge, reset cycles included.
`define TLDHB_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("hint bitmap reset check failed");

`endif

@@ hw/rtl/tldhb_pkg.sv @@
// Shared constants, command codes, state type and control structs for the
// two-level hint bitmap. No dependencies.
`default_nettype none

package tldhb_pkg;

    // Geometry of the tracked space (region size must be a power of two)
    localparam int NUM_REGIONS   = 16384;
    localparam int REGION_BYTES  = 65536;
    localparam int WORD_W        = 64;
    localparam int BIT_W         = $clog2(WORD_W);
    localparam int REGION_SHIFT  = $clog2(REGION_BYTES);
    localparam int REGION_W      = $clog2(NUM_REGIONS);
    localparam int HINT_WORDS    = (NUM_REGIONS + WORD_W - 1) / WORD_W;
    localparam int SUMMARY_WORDS = (HINT_WORDS + WORD_W - 1) / WORD_W;
    localparam int HINT_IDX_W    = $clog2(HINT_WORDS);
    localparam int SUM_IDX_W     = (SUMMARY_WORDS > 1) ? $clog2(SUMMARY_WORDS) : 1;
    localparam logic [63:0] SPACE_BYTES = 64'(NUM_REGIONS) * 64'(REGION_BYTES);

    // Field widths
    localparam int CMD_W  = 3;
    localparam int ADDR_W = 40;
    localparam int IDX_W  = 14;

    // Stream widths
    localparam int S_TDATA_W = 160;
    localparam int S_TUSER_W = CMD_W;
    localparam int M_TDATA_W = WORD_W;
    localparam int M_TUSER_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUBLISH      = 3'd0,
        CMD_CONSUME_SUM  = 3'd1,
        CMD_RESTORE_SUM  = 3'd2,
        CMD_CONSUME_HINT = 3'd3,
        CMD_RESTORE_HINT = 3'd4,
        CMD_QUERY        = 3'd5
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RMW,
        S_WALK,
        S_DRAIN,
        S_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;     // capture the accepted beat
        logic exec;     // summary ops, hint read issue
        logic rmw;      // hint read-modify-write, query evaluate
        logic walk_rd;  // publish walk: read next hint word
        logic push;     // move staged result to the output register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        t_cmd cmd;
        logic pub_skip;
        logic walk_last;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

@@ hw/rtl/tldhb_ctrl.sv @@
// Command sequencer for the hint bitmap: one beat at a time through
// exec, read-modify-write or publish walk, then result hand-off. Uses tldhb_pkg.
`default_nettype none

module tldhb_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  tldhb_pkg::t_dp_stat i_stat,
    output tldhb_pkg::t_dp_cmd  o_ctl
);
    import tldhb_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (i_stat.cmd) inside
                    CMD_PUBLISH: begin
                        n_state = i_stat.pub_skip ? S_DONE : S_WALK;
                    end
                    CMD_CONSUME_HINT, CMD_RESTORE_HINT, CMD_QUERY: begin
                        n_state = S_RMW;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_RMW: begin
                n_state = S_DONE;
            end
            S_WALK: begin
                if (i_stat.walk_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready    = 1'b0;
        o_ctl         = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_ctl.load = i_in_valid;
            end
            S_EXEC: begin
                o_ctl.exec = 1'b1;
            end
            S_RMW: begin
                o_ctl.rmw = 1'b1;
            end
            S_WALK: begin
                o_ctl.walk_rd = 1'b1;
            end
            S_DRAIN: begin
                o_ctl = '0;
            end
            S_DONE: begin
                o_ctl.push = i_stat.out_free;
            end
            default: begin
                o_ctl = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/tldhb_dp.sv @@
// Datapath of the hint bitmap: hint word memory with valid bits, summary
// registers, publish walk pipeline and output register. Uses tldhb_pkg.
`default_nettype none

module tldhb_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [tldhb_pkg::CMD_W-1:0]        i_cmd,
    input  logic [tldhb_pkg::ADDR_W-1:0]       i_address,
    input  logic [tldhb_pkg::ADDR_W-1:0]       i_length,
    input  logic [tldhb_pkg::IDX_W-1:0]        i_index,
    input  logic [tldhb_pkg::WORD_W-1:0]       i_mask,
    input  tldhb_pkg::t_dp_cmd                 i_ctl,
    output tldhb_pkg::t_dp_stat                o_stat,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [tldhb_pkg::WORD_W-1:0]       o_word_out,
    output logic                               o_pending,
    output logic                               o_bad_index
);
    import tldhb_pkg::*;

    // Captured beat
    t_cmd                  r_cmd;
    logic [IDX_W-1:0]      r_index;
    logic [WORD_W-1:0]     r_mask;
    logic                  r_skip;
    logic [REGION_W-1:0]   r_first_reg;
    logic [REGION_W-1:0]   r_last_reg;
    logic [HINT_IDX_W-1:0] r_walk;

    // Hint store
    logic [WORD_W-1:0]     hint_mem [HINT_WORDS];
    logic [HINT_WORDS-1:0] r_hvld;
    logic [WORD_W-1:0]     r_rd_data;
    logic                  r_rd_vld;

    // Walk write stage
    logic                  r_p_vld;
    logic [HINT_IDX_W-1:0] r_p_word;
    logic [WORD_W-1:0]     r_p_mask;

    // Summary store
    logic [WORD_W-1:0]     r_sum [SUMMARY_WORDS];

    // Staged and output result
    logic [WORD_W-1:0]     r_res_word;
    logic                  r_res_pend;
    logic                  r_res_bad;
    logic                  r_out_valid;
    logic [WORD_W-1:0]     r_out_word;
    logic                  r_out_pend;
    logic                  r_out_bad;

    // Publish range decode on the incoming beat
    logic                  in_skip;
    logic [ADDR_W:0]       in_end_m1;
    logic [ADDR_W:0]       in_raw_last;
    logic [REGION_W-1:0]   in_first_reg;
    logic [REGION_W-1:0]   in_last_reg;

    always_comb begin
        in_skip      = (i_length == '0) || (64'(i_address) >= SPACE_BYTES);
        in_end_m1    = {1'b0, i_address} + {1'b0, i_length} - (ADDR_W+1)'(1);
        in_raw_last  = in_end_m1 >> REGION_SHIFT;
        in_first_reg = REGION_W'(i_address >> REGION_SHIFT);
        if (in_raw_last > (ADDR_W+1)'(NUM_REGIONS - 1)) begin
            in_last_reg = REGION_W'(NUM_REGIONS - 1);
        end else begin
            in_last_reg = REGION_W'(in_raw_last);
        end
    end

    // Walk bounds and per-word bit mask
    logic [HINT_IDX_W-1:0] first_word;
    logic [HINT_IDX_W-1:0] last_word;
    logic [BIT_W-1:0]      lo_bit;
    logic [BIT_W-1:0]      hi_bit;
    logic [WORD_W-1:0]     walk_mask;
    logic                  walk_last;

    always_comb begin
        first_word = HINT_IDX_W'(r_first_reg >> BIT_W);
        last_word  = HINT_IDX_W'(r_last_reg >> BIT_W);
        lo_bit     = (r_walk == first_word) ? r_first_reg[BIT_W-1:0] : '0;
        hi_bit     = (r_walk == last_word) ? r_last_reg[BIT_W-1:0] : '1;
        walk_mask  = ({WORD_W{1'b1}} << lo_bit)
                   & ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - hi_bit));
        walk_last  = (r_walk == last_word);
    end

    // Index checks and single-word addresses
    logic                  hbad;
    logic                  sbad;
    logic                  qok;
    logic                  is_hint_cmd;
    logic [HINT_IDX_W-1:0] hint_addr;
    logic [SUM_IDX_W-1:0]  sum_idx;
    logic [WORD_W-1:0]     sum_rd;
    logic [WORD_W-1:0]     old_word;

    always_comb begin
        hbad        = 32'(r_index) >= HINT_WORDS;
        sbad        = 32'(r_index) >= SUMMARY_WORDS;
        qok         = 32'(r_index) < NUM_REGIONS;
        is_hint_cmd = (r_cmd == CMD_CONSUME_HINT) || (r_cmd == CMD_RESTORE_HINT)
                   || (r_cmd == CMD_QUERY);
        hint_addr   = (r_cmd == CMD_QUERY) ? HINT_IDX_W'(r_index >> BIT_W)
                                           : HINT_IDX_W'(r_index);
        sum_idx     = (r_cmd == CMD_QUERY) ? SUM_IDX_W'(hint_addr >> BIT_W)
                                           : SUM_IDX_W'(r_index);
        sum_rd      = r_sum[sum_idx];
        old_word    = r_rd_vld ? r_rd_data : '0;
    end

    // Hint read and write ports
    logic                  rd_en;
    logic [HINT_IDX_W-1:0] rd_addr;
    logic                  rmw_restore;
    logic                  clr_en;
    logic                  wr_en;
    logic [HINT_IDX_W-1:0] wr_addr;
    logic [WORD_W-1:0]     wr_data;
    logic [SUM_IDX_W-1:0]  sset_idx;

    always_comb begin
        rd_en       = (i_ctl.exec && is_hint_cmd) || i_ctl.walk_rd;
        rd_addr     = i_ctl.walk_rd ? r_walk : hint_addr;
        rmw_restore = i_ctl.rmw && (r_cmd == CMD_RESTORE_HINT) && !hbad && (r_mask != '0);
        clr_en      = i_ctl.rmw && (r_cmd == CMD_CONSUME_HINT) && !hbad;
        wr_en       = r_p_vld || rmw_restore;
        wr_addr     = r_p_vld ? r_p_word : hint_addr;
        wr_data     = old_word | (r_p_vld ? r_p_mask : r_mask);
        sset_idx    = SUM_IDX_W'(wr_addr >> BIT_W);
    end

    // Capture beat, advance walk pointer
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd       <= t_cmd'(i_cmd);
            r_index     <= i_index;
            r_mask      <= i_mask;
            r_skip      <= in_skip;
            r_first_reg <= in_first_reg;
            r_last_reg  <= in_last_reg;
            r_walk      <= HINT_IDX_W'(in_first_reg >> BIT_W);
        end else if (i_ctl.walk_rd) begin
            r_walk      <= r_walk + HINT_IDX_W'(1);
        end
    end

    // Hint memory: registered read, one write
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= hint_mem[rd_addr];
            r_rd_vld  <= r_hvld[rd_addr];
        end
        if (wr_en) begin
            hint_mem[wr_addr] <= wr_data;
        end
    end

    // Valid bits: set on write, drop on consume
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hvld <= '0;
        end else if (wr_en) begin
            r_hvld[wr_addr] <= 1'b1;
        end else if (clr_en) begin
            r_hvld[hint_addr] <= 1'b0;
        end
    end

    // Walk write stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else begin
            r_p_vld <= i_ctl.walk_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.walk_rd) begin
            r_p_word <= r_walk;
            r_p_mask <= walk_mask;
        end
    end

    // Summary words: mark on hint write, consume or restore on command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SUMMARY_WORDS; i++) begin
                r_sum[i] <= '0;
            end
        end else if (wr_en) begin
            r_sum[sset_idx][wr_addr[BIT_W-1:0]] <= 1'b1;
        end else if (i_ctl.exec && !sbad && (r_cmd == CMD_CONSUME_SUM)) begin
            r_sum[sum_idx] <= '0;
        end else if (i_ctl.exec && !sbad && (r_cmd == CMD_RESTORE_SUM)) begin
            r_sum[sum_idx] <= sum_rd | r_mask;
        end
    end

    // Stage the result
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_res_word <= '0;
            r_res_pend <= 1'b0;
            r_res_bad  <= 1'b0;
        end else if (i_ctl.exec) begin
            case (r_cmd)
                CMD_CONSUME_SUM: begin
                    if (sbad) begin
                        r_res_bad <= 1'b1;
                    end else begin
                        r_res_word <= sum_rd;
                    end
                end
                CMD_RESTORE_SUM: begin
                    r_res_bad <= sbad;
                end
                default: begin
                    r_res_bad <= 1'b0;
                end
            endcase
        end else if (i_ctl.rmw) begin
            case (r_cmd)
                CMD_CONSUME_HINT: begin
                    if (hbad) begin
                        r_res_bad <= 1'b1;
                    end else begin
                        r_res_word <= old_word;
                    end
                end
                CMD_RESTORE_HINT: begin
                    r_res_bad <= hbad;
                end
                CMD_QUERY: begin
                    r_res_pend <= qok && old_word[r_index[BIT_W-1:0]]
                               && sum_rd[hint_addr[BIT_W-1:0]];
                end
                default: begin
                    r_res_pend <= 1'b0;
                end
            endcase
        end
    end

    // Output register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_out_word <= r_res_word;
            r_out_pend <= r_res_pend;
            r_out_bad  <= r_res_bad;
        end
    end

    assign o_stat.cmd       = r_cmd;
    assign o_stat.pub_skip  = r_skip;
    assign o_stat.walk_last = walk_last;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_word_out  = r_out_word;
    assign o_pending   = r_out_pend;
    assign o_bad_index = r_out_bad;

endmodule

`default_nettype wire

@@ hw/rtl/two_level_dirty_hint_bitmap_top.sv @@
// Top level of the two-level hint bitmap: stream ports, field unpacking,
// sequencer and datapath. Uses tldhb_pkg, tldhb_ctrl and tldhb_dp.
//
// Usage:
//   One command beat in on the s_axis side, one result beat out on m_axis.
//   Commands: publish range, consume/restore summary word, consume/restore
//   hint word, query region. The block works on one command at a time.
//   Sequence after a beat is accepted, with the receiver ready:
//     summary commands, unknown codes, empty or outside publish: exec, done
//     hint word commands and query: exec, rmw (registered hint memory read,
//     then write), done; publish: exec, walk over the hint words covered,
//     drain, done; the walk reads one hint word per cycle while writing the previous one through the single write port.
//   s_axis_tready is high again the cycle after the result is loaded, so the
//   next beat is taken while a result still waits in the output register.
//   If the receiver stalls, the result holds in the output register and the
//   finished command waits until that register frees up.
//   Reset (synchronous, active low) clears the summary words, the hint valid
//   bits and all handshake state at once; no clearing pass follows.
`default_nettype none

module two_level_dirty_hint_bitmap_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: address[39:0], length[79:40], index[93:80], mask[157:94], zero pad
    input  logic [tldhb_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // tuser: cmd[2:0]
    input  logic [tldhb_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata: word_out[63:0]
    output logic [tldhb_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // tuser: pending[0], bad_index[1]
    output logic [tldhb_pkg::M_TUSER_W-1:0]  m_axis_tuser
);
    import tldhb_pkg::*;

    t_dp_cmd  ctl;
    t_dp_stat stat;
    logic     pending;
    logic     bad_index;

    // Sequencer
    tldhb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_ctl      (ctl)
    );

    // Datapath
    tldhb_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (s_axis_tuser[CMD_W-1:0]),
        .i_address   (s_axis_tdata[ADDR_W-1:0]),
        .i_length    (s_axis_tdata[2*ADDR_W-1:ADDR_W]),
        .i_index     (s_axis_tdata[2*ADDR_W+IDX_W-1:2*ADDR_W]),
        .i_mask      (s_axis_tdata[2*ADDR_W+IDX_W+WORD_W-1:2*ADDR_W+IDX_W]),
        .i_ctl       (ctl),
        .o_stat      (stat),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_word_out  (m_axis_tdata),
        .o_pending   (pending),
        .o_bad_index (bad_index)
    );

    assign m_axis_tuser = {bad_index, pending};

endmodule

`default_nettype wire

@@ hw/rtl/tldhb_checker.sv @@
// Port-level checks for the two-level hint bitmap, bound to the top level.
// Uses the assertion macros header and tldhb_pkg.
`default_nettype none

`include "two_level_dirty_hint_bitmap_top_macros.svh"

module tldhb_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic [tldhb_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    input  logic [tldhb_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [tldhb_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input  logic [tldhb_pkg::M_TUSER_W-1:0]  m_axis_tuser
);
    import tldhb_pkg::*;

    // A rejected index never also reports a pending region
    `TLDHB_ASSERT(a_bad_not_pending, i_clk, i_rst_n, m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))

    // A rejected index returns a zero word
    `TLDHB_ASSERT(a_bad_zero_word, i_clk, i_rst_n, (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tdata == '0))

    // One command in flight: input closes right after a beat
    `TLDHB_ASSERT(a_one_in_flight, i_clk, i_rst_n, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)

    // Stalled result holds
    `TLDHB_ASSERT(a_out_hold, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))

    // No result right after reset
    `TLDHB_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !m_axis_tvalid)

endmodule

bind two_level_dirty_hint_bitmap_top tldhb_checker u_tldhb_checker (.*);

`default_nettype wire
